/* hw/rtl/slpt_pkg.sv */
// shared types, constants and the default permission function of the page table
package slpt_pkg;

    // permission bits
    localparam logic [2:0] PERM_NONE  = 3'b000;
    localparam logic [2:0] PERM_READ  = 3'b001;
    localparam logic [2:0] PERM_WRITE = 3'b010;
    localparam logic [2:0] PERM_EXEC  = 3'b100;

    // stack occupies the top pages of the table
    localparam int STACK_PAGES = 64;

    // parameter defaults
    localparam int NUM_PAGES_DEF      = 256;
    localparam int TEXT_PAGES_DEF     = 16;
    localparam int RODATA_PAGES_DEF   = 16;
    localparam int DATA_PAGES_DEF     = 16;
    localparam int BSS_PAGES_DEF      = 16;
    localparam int HEAP_MAX_PAGES_DEF = 128;

    typedef enum logic [1:0] {
        ACT_MAP    = 2'd0,
        ACT_UNMAP  = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CHECK  = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] page_number;
        logic [7:0] frame_in;
        logic [2:0] perm_in;
        logic [2:0] access_kind;
    } in_word_t;

    typedef struct packed {
        logic       present;
        logic [7:0] frame_out;
        logic [2:0] perm_out;
        logic       allowed;
    } out_word_t;

    typedef struct packed {
        logic       present;
        logic [7:0] frame;
        logic [2:0] perm;
    } entry_t;

    // segment default permissions of a page after reset
    function automatic logic [2:0] default_perm(
        input logic [7:0] vpn,
        input int         num_pages,
        input int         text_pages,
        input int         rodata_pages,
        input int         data_pages,
        input int         bss_pages,
        input int         heap_pages
    );
        int v;
        int edge_a;
        int edge_b;
        int edge_c;
        int edge_d;
        int edge_e;
        logic [2:0] p;
        v      = int'(vpn);
        edge_a = text_pages;
        edge_b = edge_a + rodata_pages;
        edge_c = edge_b + data_pages;
        edge_d = edge_c + bss_pages;
        edge_e = edge_d + heap_pages;
        if (v < edge_a) begin
            p = PERM_READ | PERM_EXEC;
        end else if (v < edge_b) begin
            p = PERM_READ;
        end else if (v < edge_e) begin
            p = PERM_READ | PERM_WRITE;
        end else if (num_pages >= STACK_PAGES && v >= num_pages - STACK_PAGES) begin
            p = PERM_READ | PERM_WRITE;
        end else begin
            p = PERM_NONE;
        end
        return p;
    endfunction

endpackage

/* hw/rtl/slpt_ram.sv */
// entry memory: one write port, one registered read port
module slpt_ram
    import slpt_pkg::*;
#(
    parameter int DEPTH  = NUM_PAGES_DEF,
    parameter int ADDR_W = $clog2(NUM_PAGES_DEF)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data
);

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/slpt_rmw.sv */
// modify stage: picks the current entry, applies the action, builds the result word
module slpt_rmw
    import slpt_pkg::*;
#(
    parameter int NUM_PAGES      = NUM_PAGES_DEF,
    parameter int TEXT_PAGES     = TEXT_PAGES_DEF,
    parameter int RODATA_PAGES   = RODATA_PAGES_DEF,
    parameter int DATA_PAGES     = DATA_PAGES_DEF,
    parameter int BSS_PAGES      = BSS_PAGES_DEF,
    parameter int HEAP_MAX_PAGES = HEAP_MAX_PAGES_DEF
) (
    input  in_word_t  req,
    input  entry_t    ram_entry,
    input  logic      entry_valid,
    input  logic      fwd_hit,
    input  entry_t    fwd_entry,
    output logic      in_range,
    output logic      is_write,
    output entry_t    new_entry,
    output out_word_t result
);

    entry_t cur_entry;

    // range check against the table depth
    assign in_range = 9'({1'b0, req.page_number}) < 9'(NUM_PAGES);

    // current entry: forwarded, stored, or reset default
    always_comb begin
        if (fwd_hit) begin
            cur_entry = fwd_entry;
        end else if (entry_valid) begin
            cur_entry = ram_entry;
        end else begin
            cur_entry.present = 1'b0;
            cur_entry.frame   = 8'd0;
            cur_entry.perm    = default_perm(req.page_number, NUM_PAGES, TEXT_PAGES,
                                             RODATA_PAGES, DATA_PAGES, BSS_PAGES,
                                             HEAP_MAX_PAGES);
        end
    end

    // apply the action
    always_comb begin
        new_entry = cur_entry;
        is_write  = 1'b0;
        case (req.action)
            ACT_MAP: begin
                new_entry.present = 1'b1;
                new_entry.frame   = req.frame_in;
                new_entry.perm    = req.perm_in;
                is_write          = in_range;
            end
            ACT_UNMAP: begin
                new_entry.present = 1'b0;
                new_entry.frame   = 8'd0;
                is_write          = in_range;
            end
            default: begin
                new_entry = cur_entry;
            end
        endcase
    end

    // result word, all zero for a page beyond the table
    always_comb begin
        if (in_range) begin
            result.present   = new_entry.present;
            result.frame_out = new_entry.frame;
            result.perm_out  = new_entry.perm;
            result.allowed   = (new_entry.perm & req.access_kind) == req.access_kind;
        end else begin
            result = '0;
        end
    end

endmodule

/* hw/rtl/single_level_page_table.sv */
// page table top: read stage, modify/write stage, output register
// throughput: one word per cycle while the output is not stalled by m_ready;
// the single entry memory read/write port pair sets this
// back-to-back writes to the same page are forwarded around the memory read
// reset: synchronous, active low; clears all entry valid bits so every page reads
// not present, frame 0, segment default permissions at once (no clearing pass)
module single_level_page_table
    import slpt_pkg::*;
#(
    parameter int NUM_PAGES      = NUM_PAGES_DEF,
    parameter int TEXT_PAGES     = TEXT_PAGES_DEF,
    parameter int RODATA_PAGES   = RODATA_PAGES_DEF,
    parameter int DATA_PAGES     = DATA_PAGES_DEF,
    parameter int BSS_PAGES      = BSS_PAGES_DEF,
    parameter int HEAP_MAX_PAGES = HEAP_MAX_PAGES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int IDX_W = $clog2(NUM_PAGES);

    logic                 st1_valid_reg;
    logic                 st1_valid_next;
    in_word_t             st1_req_reg;
    logic                 fwd_hit_reg;
    entry_t               fwd_entry_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_word_t            out_word_reg;
    logic [NUM_PAGES-1:0] valid_reg;

    logic       s_fire;
    logic       st1_advance;
    logic       wr_en;
    logic       in_range;
    logic       is_write;
    logic       entry_valid;
    entry_t     ram_q;
    entry_t     new_entry;
    out_word_t  result;
    logic [IDX_W-1:0] st1_idx;

    // handshake
    assign st1_advance = st1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready     = !st1_valid_reg || st1_advance;
    assign s_fire      = s_valid && s_ready;
    assign wr_en       = st1_advance && is_write;
    assign st1_idx     = st1_req_reg.page_number[IDX_W-1:0];
    assign entry_valid = in_range && valid_reg[st1_idx];

    slpt_ram #(
        .DEPTH  (NUM_PAGES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (s_data.page_number[IDX_W-1:0]),
        .rd_data (ram_q),
        .wr_en   (wr_en),
        .wr_addr (st1_idx),
        .wr_data (new_entry)
    );

    slpt_rmw #(
        .NUM_PAGES      (NUM_PAGES),
        .TEXT_PAGES     (TEXT_PAGES),
        .RODATA_PAGES   (RODATA_PAGES),
        .DATA_PAGES     (DATA_PAGES),
        .BSS_PAGES      (BSS_PAGES),
        .HEAP_MAX_PAGES (HEAP_MAX_PAGES)
    ) u_rmw (
        .req         (st1_req_reg),
        .ram_entry   (ram_q),
        .entry_valid (entry_valid),
        .fwd_hit     (fwd_hit_reg),
        .fwd_entry   (fwd_entry_reg),
        .in_range    (in_range),
        .is_write    (is_write),
        .new_entry   (new_entry),
        .result      (result)
    );

    // stage and output valid next values
    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_fire) begin
            st1_valid_next = 1'b1;
        end else if (st1_advance) begin
            st1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (st1_advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers and entry valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            valid_reg     <= '0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s_fire) begin
                fwd_hit_reg <= wr_en && (st1_req_reg.page_number == s_data.page_number);
            end
            if (wr_en) begin
                valid_reg[st1_idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_req_reg   <= s_data;
            fwd_entry_reg <= new_entry;
        end
        if (st1_advance) begin
            out_word_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

`ifndef NO_ASSERTIONS
    // an entry that is not present never carries a frame
    a_unmapped_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.present |-> m_data.frame_out == 8'd0)
        else $error("result not present with nonzero frame");

    // a stalled modify stage blocks new words
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && out_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted while modify stage stalled");

    // forwarding only applies to a word held in the modify stage
    a_fwd_needs_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && wr_en && (st1_req_reg.page_number == s_data.page_number)
        |=> fwd_hit_reg && st1_valid_reg)
        else $error("same-page write not forwarded");
`endif

endmodule

/* test/testbench.sv */
// self-checking testbench for the single level page table: directed table plus random traffic
module testbench;
    import slpt_pkg::*;

    localparam int N_PAGES     = NUM_PAGES_DEF;
    localparam int N_TEXT      = TEXT_PAGES_DEF;
    localparam int N_RODATA    = RODATA_PAGES_DEF;
    localparam int N_DATA      = DATA_PAGES_DEF;
    localparam int N_BSS       = BSS_PAGES_DEF;
    localparam int N_HEAP      = HEAP_MAX_PAGES_DEF;
    localparam int RAND_WORDS  = 1800;
    localparam int CALM_TAIL   = 300;
    localparam int DRAIN_TICKS = 8;

    // one stimulus row: the word and, where obvious, its result
    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t view;
    } req_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    // shadow copy of the table, the words presented but not yet taken, and the results still owed by the block
    entry_t    page_tbl [N_PAGES];
    out_word_t entry_view_q [$];
    req_row_t  req_meta_q [$];

    bit snd_idle;
    bit rcv_idle;
    int hot_base;
    int n_errors;
    int n_results;
    int n_drains;
    int act_cnt [4];
    int boundary_pages [10] = '{0, 15, 16, 31, 32, 63, 64, 191, 192, 255};

    always #2 aclk = ~aclk;

    single_level_page_table #(
        .NUM_PAGES      (N_PAGES),
        .TEXT_PAGES     (N_TEXT),
        .RODATA_PAGES   (N_RODATA),
        .DATA_PAGES     (N_DATA),
        .BSS_PAGES      (N_BSS),
        .HEAP_MAX_PAGES (N_HEAP)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // permissions a page gets from its segment after reset
    function automatic logic [2:0] segment_perm(input int pg);
        int bound;
        bound = N_TEXT;
        if (pg < bound) return PERM_READ | PERM_EXEC;
        bound += N_RODATA;
        if (pg < bound) return PERM_READ;
        bound += N_DATA + N_BSS + N_HEAP;
        if (pg < bound) return PERM_READ | PERM_WRITE;
        if (N_PAGES >= STACK_PAGES && pg >= N_PAGES - STACK_PAGES) return PERM_READ | PERM_WRITE;
        return PERM_NONE;
    endfunction

    function automatic void reset_page_tbl();
        for (int pg = 0; pg < N_PAGES; pg++) begin
            page_tbl[pg].present = 1'b0;
            page_tbl[pg].frame   = 8'd0;
            page_tbl[pg].perm    = segment_perm(pg);
        end
    endfunction

    // apply one word to the shadow table and return the entry it leaves behind
    function automatic out_word_t apply_page_op(input in_word_t w);
        out_word_t r;
        int        pg;
        r  = '0;
        pg = int'(w.page_number);
        if (pg >= N_PAGES) return r;
        case (w.action)
            ACT_MAP: begin
                page_tbl[pg].present = 1'b1;
                page_tbl[pg].frame   = w.frame_in;
                page_tbl[pg].perm    = w.perm_in;
            end
            ACT_UNMAP: begin
                page_tbl[pg].present = 1'b0;
                page_tbl[pg].frame   = 8'd0;
            end
            default: begin
            end
        endcase
        r.present   = page_tbl[pg].present;
        r.frame_out = page_tbl[pg].frame;
        r.perm_out  = page_tbl[pg].perm;
        r.allowed   = ((page_tbl[pg].perm & w.access_kind) == w.access_kind);
        return r;
    endfunction

    function automatic req_row_t dir_row(
        input action_t    act,
        input int         pg,
        input int         fr,
        input logic [2:0] pm,
        input logic [2:0] kd,
        input bit         typed,
        input bit         pr,
        input int         fo,
        input logic [2:0] po,
        input bit         al
    );
        req_row_t row;
        row.word.action      = act;
        row.word.page_number = pg[7:0];
        row.word.frame_in    = fr[7:0];
        row.word.perm_in     = pm;
        row.word.access_kind = kd;
        row.typed            = typed;
        row.view.present     = pr;
        row.view.frame_out   = fo[7:0];
        row.view.perm_out    = po;
        row.view.allowed     = al;
        return row;
    endfunction

    // random word; pages cluster around a moving hot spot so entries get reused
    function automatic req_row_t rand_row();
        req_row_t row;
        int       pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 63) == 0) hot_base = $urandom_range(0, 252);
        row.word.action = action_t'($urandom_range(0, 3));
        if (pick < 45) begin
            row.word.page_number = 8'(hot_base + $urandom_range(0, 3));
        end else if (pick < 60) begin
            row.word.page_number = 8'(boundary_pages[$urandom_range(0, 9)]);
        end else begin
            row.word.page_number = 8'($urandom_range(0, 255));
        end
        row.word.frame_in    = 8'($urandom_range(0, 255));
        row.word.perm_in     = 3'($urandom_range(0, 7));
        row.word.access_kind = 3'($urandom_range(0, 7));
        row.typed            = 1'b0;
        row.view             = '0;
        return row;
    endfunction

    task automatic compare_view(input out_word_t want, input out_word_t got);
        if (got.present !== want.present) begin
            $error("present: expected %0b, got %0b", want.present, got.present);
            n_errors++;
        end
        if (got.frame_out !== want.frame_out) begin
            $error("frame_out: expected %0d, got %0d", want.frame_out, got.frame_out);
            n_errors++;
        end
        if (got.perm_out !== want.perm_out) begin
            $error("perm_out: expected %0d, got %0d", want.perm_out, got.perm_out);
            n_errors++;
        end
        if (got.allowed !== want.allowed) begin
            $error("allowed: expected %0b, got %0b", want.allowed, got.allowed);
            n_errors++;
        end
    endtask

    // present one word and hold it until the block takes it
    task automatic send_word(input req_row_t row);
        req_meta_q.push_back(row);
        s_valid <= 1'b1;
        s_data  <= row.word;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic sender_gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge aclk);
    endtask

    // drop valid, then wait for every owed result
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (entry_view_q.size() != 0 || req_meta_q.size() != 0) @(posedge aclk);
        n_drains++;
    endtask

    // accepted words feed the shadow table, accepted results are checked in order
    always @(posedge aclk) begin : monitor
        req_row_t  row;
        out_word_t pred;
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready === 1'b1) begin
                if (req_meta_q.size() == 0) begin
                    $error("word accepted with nothing presented");
                    n_errors++;
                end else begin
                    row  = req_meta_q.pop_front();
                    pred = apply_page_op(row.word);
                    entry_view_q.push_back(row.typed ? row.view : pred);
                    act_cnt[int'(row.word.action)]++;
                end
            end
            if (m_valid === 1'b1 && m_ready) begin
                if (entry_view_q.size() == 0) begin
                    $error("result word with no expectation pending");
                    n_errors++;
                end else begin
                    compare_view(entry_view_q.pop_front(), m_data);
                    n_results++;
                end
            end
        end
    end

    // result side back-pressure in random bursts
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (rcv_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // stimulus
    initial begin
        req_row_t dir_rows [$];
        int       seg;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        snd_idle  = 1'b1;
        rcv_idle  = 1'b1;
        hot_base  = 120;
        n_errors  = 0;
        n_results = 0;
        n_drains  = 0;
        foreach (act_cnt[k]) act_cnt[k] = 0;
        reset_page_tbl();

        // reset defaults at segment boundaries
        dir_rows.push_back(dir_row(ACT_LOOKUP, 0, 0, PERM_NONE, PERM_NONE,
                                   1, 0, 0, PERM_READ | PERM_EXEC, 1));
        dir_rows.push_back(dir_row(ACT_LOOKUP, 255, 0, PERM_NONE, 3'b111,
                                   1, 0, 0, PERM_READ | PERM_WRITE, 0));
        dir_rows.push_back(dir_row(ACT_CHECK, 16, 0, PERM_NONE, PERM_READ,
                                   1, 0, 0, PERM_READ, 1));
        dir_rows.push_back(dir_row(ACT_CHECK, 31, 0, PERM_NONE, PERM_WRITE,
                                   1, 0, 0, PERM_READ, 0));
        dir_rows.push_back(dir_row(ACT_CHECK, 32, 0, PERM_NONE, PERM_READ | PERM_WRITE,
                                   1, 0, 0, PERM_READ | PERM_WRITE, 1));
        dir_rows.push_back(dir_row(ACT_CHECK, 191, 0, PERM_NONE, PERM_EXEC,
                                   1, 0, 0, PERM_READ | PERM_WRITE, 0));
        dir_rows.push_back(dir_row(ACT_CHECK, 192, 0, PERM_NONE, PERM_READ | PERM_WRITE,
                                   1, 0, 0, PERM_READ | PERM_WRITE, 1));
        dir_rows.push_back(dir_row(ACT_CHECK, 15, 0, PERM_NONE, PERM_READ | PERM_EXEC,
                                   1, 0, 0, PERM_READ | PERM_EXEC, 1));
        // map and look up at the extremes of page, frame and permissions
        dir_rows.push_back(dir_row(ACT_MAP, 0, 255, 3'b111, 3'b111,
                                   1, 1, 255, 3'b111, 1));
        dir_rows.push_back(dir_row(ACT_LOOKUP, 0, 0, PERM_NONE, PERM_NONE,
                                   0, 0, 0, PERM_NONE, 0));
        // zero requested bits are always allowed
        dir_rows.push_back(dir_row(ACT_MAP, 255, 0, PERM_NONE, PERM_NONE,
                                   1, 1, 0, PERM_NONE, 1));
        dir_rows.push_back(dir_row(ACT_CHECK, 255, 0, PERM_NONE, PERM_READ,
                                   1, 1, 0, PERM_NONE, 0));
        // unmap keeps permissions, allowed computed on every action
        dir_rows.push_back(dir_row(ACT_UNMAP, 0, 77, PERM_NONE, 3'b111,
                                   1, 0, 0, 3'b111, 1));
        dir_rows.push_back(dir_row(ACT_UNMAP, 255, 0, PERM_NONE, PERM_NONE,
                                   1, 0, 0, PERM_NONE, 1));
        // back to back writes to one page
        dir_rows.push_back(dir_row(ACT_MAP, 128, 170, PERM_READ | PERM_EXEC, PERM_WRITE,
                                   0, 0, 0, PERM_NONE, 0));
        dir_rows.push_back(dir_row(ACT_MAP, 128, 85, PERM_WRITE, PERM_WRITE,
                                   0, 0, 0, PERM_NONE, 0));
        dir_rows.push_back(dir_row(ACT_CHECK, 128, 0, PERM_NONE, PERM_WRITE | PERM_EXEC,
                                   0, 0, 0, PERM_NONE, 0));
        dir_rows.push_back(dir_row(ACT_UNMAP, 128, 0, PERM_NONE, PERM_WRITE,
                                   0, 0, 0, PERM_NONE, 0));
        dir_rows.push_back(dir_row(ACT_LOOKUP, 128, 0, PERM_NONE, 3'b111,
                                   0, 0, 0, PERM_NONE, 0));
        dir_rows.push_back(dir_row(ACT_LOOKUP, 63, 0, PERM_NONE, PERM_READ | PERM_WRITE,
                                   0, 0, 0, PERM_NONE, 0));
        dir_rows.push_back(dir_row(ACT_LOOKUP, 64, 0, PERM_NONE, PERM_EXEC,
                                   0, 0, 0, PERM_NONE, 0));
        dir_rows.push_back(dir_row(ACT_UNMAP, 100, 0, PERM_NONE, PERM_READ,
                                   0, 0, 0, PERM_NONE, 0));
        dir_rows.push_back(dir_row(ACT_CHECK, 200, 0, PERM_NONE, PERM_NONE,
                                   0, 0, 0, PERM_NONE, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (dir_rows[k]) begin
            send_word(dir_rows[k]);
            if (snd_idle && $urandom_range(0, 3) == 0) sender_gap();
        end
        wait_drained();

        // random traffic; every fifth block and the tail run without sender gaps or result back-pressure
        for (int i = 0; i < RAND_WORDS; i++) begin
            seg      = i / 100;
            snd_idle = (i < RAND_WORDS - CALM_TAIL) && (seg % 5 != 4);
            rcv_idle = snd_idle;
            if (i == RAND_WORDS / 2) wait_drained();
            send_word(rand_row());
            if (snd_idle && $urandom_range(0, 5) == 0) sender_gap();
        end

        wait_drained();
        repeat (DRAIN_TICKS) @(posedge aclk);

        $display("covered %0d map, %0d unmap, %0d lookup, %0d check words, %0d idle drains",
                 act_cnt[ACT_MAP], act_cnt[ACT_UNMAP], act_cnt[ACT_LOOKUP],
                 act_cnt[ACT_CHECK], n_drains);
        $display("compared %0d result words, %0d field mismatches", n_results, n_errors);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", entry_view_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
